// ----- rtl/bhs_pkg.sv -----
// Bale handler sequencer package: phase and wait codes, relay bit positions,
// the sequencer state and the switch and result records.
// No dependencies; used by bhs_step, the top level and the testbench.
package bhs_pkg;

	localparam int RELAY_W = 6;
	localparam int CNT_W   = 16;

	localparam logic [CNT_W-1:0] IGNORE_RESET = CNT_W'(2000);
	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

	localparam int RB_PUSH_OUT  = 0;
	localparam int RB_PUSH_IN   = 1;
	localparam int RB_SWEEP_OUT = 2;
	localparam int RB_SWEEP_IN  = 3;
	localparam int RB_LOAD      = 4;
	localparam int RB_UNLOAD    = 5;

	typedef enum logic [2:0] {
		PH_HOME      = 3'd0,
		PH_LOAD      = 3'd1,
		PH_SWEEP_OUT = 3'd2,
		PH_SWEEP_IN  = 3'd3,
		PH_PUSH_OUT  = 3'd4,
		PH_PUSH_IN   = 3'd5,
		PH_UNLOAD    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		WT_NONE         = 3'd0,
		WT_PUSH_HOME    = 3'd1,
		WT_SWEEP_HOME   = 3'd2,
		WT_UNLOAD_HOME  = 3'd3,
		WT_ROW_READY    = 3'd4,
		WT_PUSH_OUT     = 3'd5,
		WT_SWEEP_OUT    = 3'd6,
		WT_UNLOAD_CLOSE = 3'd7
	} wait_t;

	typedef struct packed {
		phase_t             phase;
		logic [RELAY_W-1:0] relay;
		logic               wait_done;
		logic [CNT_W-1:0]   count;
	} seq_state_t;

	typedef struct packed {
		logic push_home;
		logic push_extended;
		logic sweep_home;
		logic sweep_extended;
		logic unload_home;
		logic row_ready;
		logic load_full;
		logic row_swept;
	} sw_t;

	typedef struct packed {
		phase_t             phase_code;
		logic [RELAY_W-1:0] relay;
		wait_t              wait_code;
	} result_t;

endpackage

// ----- rtl/bhs_ifs.sv -----
// Valid/ready channels of the bale handler sequencer: switch items in,
// result items out, and the configuration write channel.
// No dependencies.
interface bhs_tick_if;
	logic valid;
	logic ready;
	logic sw_push_home;
	logic sw_push_extended;
	logic sw_sweep_home;
	logic sw_sweep_extended;
	logic sw_unload_home;
	logic sw_row_ready;
	logic sw_load_full;
	logic sw_row_swept;

	modport source (output valid, sw_push_home, sw_push_extended, sw_sweep_home,
		sw_sweep_extended, sw_unload_home, sw_row_ready, sw_load_full, sw_row_swept,
		input ready);
	modport sink (input valid, sw_push_home, sw_push_extended, sw_sweep_home,
		sw_sweep_extended, sw_unload_home, sw_row_ready, sw_load_full, sw_row_swept,
		output ready);
endinterface

interface bhs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase_code;
	logic       relay_push_out;
	logic       relay_push_in;
	logic       relay_sweep_out;
	logic       relay_sweep_in;
	logic       relay_load_chain;
	logic       relay_unload_chain;
	logic [2:0] wait_code;

	modport source (output valid, phase_code, relay_push_out, relay_push_in,
		relay_sweep_out, relay_sweep_in, relay_load_chain, relay_unload_chain, wait_code,
		input ready);
	modport sink (input valid, phase_code, relay_push_out, relay_push_in,
		relay_sweep_out, relay_sweep_in, relay_load_chain, relay_unload_chain, wait_code,
		output ready);
endinterface

interface bhs_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] unload_ignore_ticks;

	modport source (output valid, unload_ignore_ticks, input ready);
	modport sink (input valid, unload_ignore_ticks, output ready);
endinterface

// ----- rtl/bhs_step.sv -----
// Next-state decode of the sequencer: relays, phase change, unload ignore
// window and wait code for one switch item. Uses bhs_pkg.
module bhs_step (
	input  bhs_pkg::seq_state_t        cur,
	input  bhs_pkg::sw_t               sw,
	input  logic [bhs_pkg::CNT_W-1:0]  ignore_ticks,
	output bhs_pkg::seq_state_t        nxt,
	output bhs_pkg::wait_t             wait_code
);

	logic [bhs_pkg::CNT_W-1:0] cnt_inc;

	assign cnt_inc = (cur.count != bhs_pkg::CNT_MAX) ? cur.count + 1'b1 : cur.count;

	always_comb begin
		nxt       = cur;
		wait_code = bhs_pkg::WT_NONE;
		case (cur.phase)
			bhs_pkg::PH_HOME: begin
				nxt.relay[bhs_pkg::RB_LOAD]      = 1'b0;
				nxt.relay[bhs_pkg::RB_PUSH_OUT]  = 1'b0;
				nxt.relay[bhs_pkg::RB_SWEEP_OUT] = 1'b0;
				if (!sw.push_home) begin
					nxt.relay[bhs_pkg::RB_PUSH_IN] = 1'b1;
					wait_code = bhs_pkg::WT_PUSH_HOME;
				end else begin
					nxt.relay[bhs_pkg::RB_PUSH_IN] = 1'b0;
					if (!sw.sweep_home) begin
						nxt.relay[bhs_pkg::RB_SWEEP_IN] = 1'b1;
						wait_code = bhs_pkg::WT_SWEEP_HOME;
					end else begin
						nxt.relay[bhs_pkg::RB_SWEEP_IN] = 1'b0;
						if (!sw.unload_home) begin
							nxt.relay[bhs_pkg::RB_UNLOAD] = 1'b1;
							wait_code = bhs_pkg::WT_UNLOAD_HOME;
						end else begin
							nxt.relay[bhs_pkg::RB_UNLOAD] = 1'b0;
							nxt.phase = bhs_pkg::PH_LOAD;
						end
					end
				end
			end
			bhs_pkg::PH_LOAD: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_LOAD] = !sw.row_ready;
				if (!sw.row_ready) begin
					wait_code = bhs_pkg::WT_ROW_READY;
				end else begin
					nxt.phase = sw.row_swept ? bhs_pkg::PH_PUSH_OUT : bhs_pkg::PH_SWEEP_OUT;
				end
			end
			bhs_pkg::PH_SWEEP_OUT: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_SWEEP_OUT] = !sw.sweep_extended;
				if (!sw.sweep_extended) begin
					wait_code = bhs_pkg::WT_SWEEP_OUT;
				end else begin
					nxt.phase = bhs_pkg::PH_SWEEP_IN;
				end
			end
			bhs_pkg::PH_SWEEP_IN: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_SWEEP_IN] = !sw.sweep_home;
				if (!sw.sweep_home) begin
					wait_code = bhs_pkg::WT_SWEEP_HOME;
				end else begin
					nxt.phase = bhs_pkg::PH_LOAD;
				end
			end
			bhs_pkg::PH_PUSH_OUT: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_PUSH_OUT] = !sw.push_extended && !sw.load_full;
				if (!sw.push_extended && !sw.load_full) begin
					wait_code = bhs_pkg::WT_PUSH_OUT;
				end else begin
					nxt.phase = bhs_pkg::PH_PUSH_IN;
				end
			end
			bhs_pkg::PH_PUSH_IN: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_PUSH_IN] = !sw.push_home;
				if (!sw.push_home) begin
					wait_code = bhs_pkg::WT_PUSH_HOME;
				end else if (sw.load_full) begin
					nxt.wait_done = 1'b0;
					nxt.count     = '0;
					nxt.phase     = bhs_pkg::PH_UNLOAD;
				end else begin
					nxt.phase = bhs_pkg::PH_LOAD;
				end
			end
			bhs_pkg::PH_UNLOAD: begin
				nxt.relay = '0;
				nxt.relay[bhs_pkg::RB_UNLOAD] = 1'b1;
				if (!cur.wait_done) begin
					nxt.count     = cnt_inc;
					nxt.wait_done = (cnt_inc >= ignore_ticks);
				end else if (!sw.unload_home) begin
					wait_code = bhs_pkg::WT_UNLOAD_CLOSE;
				end else begin
					nxt.relay = '0;
					nxt.phase = bhs_pkg::PH_LOAD;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ----- rtl/bale_handler_sequencer_top.sv -----
// Bale handler sequencer top level: input register, phase state, result
// register, configuration register. Uses bhs_pkg, bhs_ifs and bhs_step.
//
// One switch item is taken every clock while results are taken. After
// acceptance the item is captured in an input register, the phase,
// relay and unload-window state is updated by one pass of the step decode,
// and the result is held in an output register until taken. Throughput is
// one item per clock as long as results are taken; a stalled result holds
// both registers and drops tick.ready once the input register is also full.
// unload_ignore_ticks resets to 2000 and may be written while no item is in
// flight; cfg.ready is always high.
module bale_handler_sequencer_top (
	input logic          clk,
	input logic          arst_n,
	bhs_tick_if.sink     tick,
	bhs_result_if.source result,
	bhs_cfg_if.sink      cfg
);

	logic                      valid_s1;
	bhs_pkg::sw_t              sw_s1;
	logic                      out_valid_q;
	bhs_pkg::result_t          res_q;
	bhs_pkg::seq_state_t       state_q;
	bhs_pkg::seq_state_t       state_nxt;
	bhs_pkg::wait_t            wait_nxt;
	logic [bhs_pkg::CNT_W-1:0] ignore_q;
	logic                      advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	bhs_step u_step (
		.cur          (state_q),
		.sw           (sw_s1),
		.ignore_ticks (ignore_q),
		.nxt          (state_nxt),
		.wait_code    (wait_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			sw_s1 <= '{push_home:      tick.sw_push_home,
			           push_extended:  tick.sw_push_extended,
			           sweep_home:     tick.sw_sweep_home,
			           sweep_extended: tick.sw_sweep_extended,
			           unload_home:    tick.sw_unload_home,
			           row_ready:      tick.sw_row_ready,
			           load_full:      tick.sw_load_full,
			           row_swept:      tick.sw_row_swept};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: bhs_pkg::PH_HOME, relay: '0, wait_done: 1'b0, count: '0};
			out_valid_q <= 1'b0;
			ignore_q    <= bhs_pkg::IGNORE_RESET;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				ignore_q <= cfg.unload_ignore_ticks;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{phase_code: state_q.phase, relay: state_nxt.relay, wait_code: wait_nxt};
		end
	end

	assign result.valid              = out_valid_q;
	assign result.phase_code         = res_q.phase_code;
	assign result.relay_push_out     = res_q.relay[bhs_pkg::RB_PUSH_OUT];
	assign result.relay_push_in      = res_q.relay[bhs_pkg::RB_PUSH_IN];
	assign result.relay_sweep_out    = res_q.relay[bhs_pkg::RB_SWEEP_OUT];
	assign result.relay_sweep_in     = res_q.relay[bhs_pkg::RB_SWEEP_IN];
	assign result.relay_load_chain   = res_q.relay[bhs_pkg::RB_LOAD];
	assign result.relay_unload_chain = res_q.relay[bhs_pkg::RB_UNLOAD];
	assign result.wait_code          = res_q.wait_code;

	// outside the home phase at most one relay is ever on
	a_relay_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.phase_code != bhs_pkg::PH_HOME) |-> $onehot0(res_q.relay))
		else $error("more than one relay on outside home phase");

	// a tick that reports a wait leaves the phase unchanged
	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && wait_nxt != bhs_pkg::WT_NONE) |=> (state_q.phase == $past(state_q.phase)))
		else $error("phase changed on a waiting tick");

	// every ignored unload tick counts
	a_ignore_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.phase == bhs_pkg::PH_UNLOAD && !state_q.wait_done)
			|=> (state_q.count != '0))
		else $error("unload ignore counter did not advance");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for bale_handler_sequencer_top: switch items are driven
// on the tick channel, each result is compared with a predictor of the phase machine.
// Depends on rtl/bhs_pkg.sv, rtl/bhs_ifs.sv and rtl/bale_handler_sequencer_top.sv.
module tb_top;

	logic clk = 1'b0;
	logic arst_n;

	bhs_tick_if   tick_ch();
	bhs_result_if res_ch();
	bhs_cfg_if    cfg_ch();

	bale_handler_sequencer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted sequencer state
	bhs_pkg::phase_t             seq_phase;
	logic [bhs_pkg::RELAY_W-1:0] seq_relay;
	logic                        seq_done;
	logic [bhs_pkg::CNT_W-1:0]   seq_count;
	logic [bhs_pkg::CNT_W-1:0]   seq_ignore;

	bhs_pkg::result_t expected_results[$];

	int  mismatches   = 0;
	int  ticks_sent   = 0;
	int  results_seen = 0;
	int  unload_runs  = 0;
	int  cfg_writes   = 0;
	int  phase_hits[8];
	bit  tx_idle_on   = 1'b1;
	bit  rx_idle_on   = 1'b1;
	logic rx_hold     = 1'b0;
	int  hold_len     = 0;
	event hold_go;

	function automatic logic [bhs_pkg::RELAY_W-1:0] relay_only(int idx, logic on);
		logic [bhs_pkg::RELAY_W-1:0] v;
		v = '0;
		v[idx] = on;
		return v;
	endfunction

	function automatic bhs_pkg::result_t advance_sequencer(bhs_pkg::sw_t s);
		bhs_pkg::result_t r;
		bhs_pkg::phase_t  start;
		bhs_pkg::wait_t   w;
		logic             go;
		start = seq_phase;
		w = bhs_pkg::WT_NONE;
		case (start)
			bhs_pkg::PH_HOME: begin
				seq_relay[bhs_pkg::RB_LOAD] = 1'b0;
				seq_relay[bhs_pkg::RB_PUSH_OUT] = 1'b0;
				seq_relay[bhs_pkg::RB_SWEEP_OUT] = 1'b0;
				if (!s.push_home) begin
					seq_relay[bhs_pkg::RB_PUSH_IN] = 1'b1;
					w = bhs_pkg::WT_PUSH_HOME;
				end else begin
					seq_relay[bhs_pkg::RB_PUSH_IN] = 1'b0;
					if (!s.sweep_home) begin
						seq_relay[bhs_pkg::RB_SWEEP_IN] = 1'b1;
						w = bhs_pkg::WT_SWEEP_HOME;
					end else begin
						seq_relay[bhs_pkg::RB_SWEEP_IN] = 1'b0;
						if (!s.unload_home) begin
							seq_relay[bhs_pkg::RB_UNLOAD] = 1'b1;
							w = bhs_pkg::WT_UNLOAD_HOME;
						end else begin
							seq_relay[bhs_pkg::RB_UNLOAD] = 1'b0;
							seq_phase = bhs_pkg::PH_LOAD;
						end
					end
				end
			end
			bhs_pkg::PH_LOAD: begin
				seq_relay = relay_only(bhs_pkg::RB_LOAD, !s.row_ready);
				if (!s.row_ready)
					w = bhs_pkg::WT_ROW_READY;
				else
					seq_phase = s.row_swept ? bhs_pkg::PH_PUSH_OUT : bhs_pkg::PH_SWEEP_OUT;
			end
			bhs_pkg::PH_SWEEP_OUT: begin
				seq_relay = relay_only(bhs_pkg::RB_SWEEP_OUT, !s.sweep_extended);
				if (!s.sweep_extended)
					w = bhs_pkg::WT_SWEEP_OUT;
				else
					seq_phase = bhs_pkg::PH_SWEEP_IN;
			end
			bhs_pkg::PH_SWEEP_IN: begin
				seq_relay = relay_only(bhs_pkg::RB_SWEEP_IN, !s.sweep_home);
				if (!s.sweep_home)
					w = bhs_pkg::WT_SWEEP_HOME;
				else
					seq_phase = bhs_pkg::PH_LOAD;
			end
			bhs_pkg::PH_PUSH_OUT: begin
				go = !s.push_extended && !s.load_full;
				seq_relay = relay_only(bhs_pkg::RB_PUSH_OUT, go);
				if (go)
					w = bhs_pkg::WT_PUSH_OUT;
				else
					seq_phase = bhs_pkg::PH_PUSH_IN;
			end
			bhs_pkg::PH_PUSH_IN: begin
				seq_relay = relay_only(bhs_pkg::RB_PUSH_IN, !s.push_home);
				if (!s.push_home) begin
					w = bhs_pkg::WT_PUSH_HOME;
				end else if (s.load_full) begin
					seq_done = 1'b0;
					seq_count = '0;
					seq_phase = bhs_pkg::PH_UNLOAD;
					unload_runs++;
				end else begin
					seq_phase = bhs_pkg::PH_LOAD;
				end
			end
			bhs_pkg::PH_UNLOAD: begin
				seq_relay = relay_only(bhs_pkg::RB_UNLOAD, 1'b1);
				if (!seq_done) begin
					if (seq_count != bhs_pkg::CNT_MAX)
						seq_count++;
					if (seq_count >= seq_ignore)
						seq_done = 1'b1;
				end else if (!s.unload_home) begin
					w = bhs_pkg::WT_UNLOAD_CLOSE;
				end else begin
					seq_relay = '0;
					seq_phase = bhs_pkg::PH_LOAD;
				end
			end
			default: ;
		endcase
		phase_hits[start]++;
		r.phase_code = start;
		r.relay = seq_relay;
		r.wait_code = w;
		return r;
	endfunction

	// random switches, half the time nudged toward the goal of the current phase
	function automatic bhs_pkg::sw_t steer_switches();
		bhs_pkg::sw_t s;
		s = bhs_pkg::sw_t'(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 1))
			return s;
		case (seq_phase)
			bhs_pkg::PH_HOME: begin
				s.push_home = 1'b1;
				s.sweep_home = 1'b1;
				s.unload_home = 1'b1;
			end
			bhs_pkg::PH_LOAD:      s.row_ready = 1'b1;
			bhs_pkg::PH_SWEEP_OUT: s.sweep_extended = 1'b1;
			bhs_pkg::PH_SWEEP_IN:  s.sweep_home = 1'b1;
			bhs_pkg::PH_PUSH_OUT: begin
				if ($urandom_range(0, 1))
					s.push_extended = 1'b1;
				else
					s.load_full = 1'b1;
			end
			bhs_pkg::PH_PUSH_IN:   s.push_home = 1'b1;
			bhs_pkg::PH_UNLOAD:    s.unload_home = 1'b1;
			default: ;
		endcase
		return s;
	endfunction

	function automatic bhs_pkg::sw_t switch_levels(bit ph, bit pe, bit sh, bit se, bit uh,
			bit rr, bit lf, bit rs);
		return {ph, pe, sh, se, uh, rr, lf, rs};
	endfunction

	function automatic void check_field(string what, logic [2:0] want, logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_tick(bhs_pkg::sw_t s, bit no_gap);
		int gap;
		gap = (no_gap || !tx_idle_on) ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			tick_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid             = 1'b1;
		tick_ch.sw_push_home      = s.push_home;
		tick_ch.sw_push_extended  = s.push_extended;
		tick_ch.sw_sweep_home     = s.sweep_home;
		tick_ch.sw_sweep_extended = s.sweep_extended;
		tick_ch.sw_unload_home    = s.unload_home;
		tick_ch.sw_row_ready      = s.row_ready;
		tick_ch.sw_load_full      = s.load_full;
		tick_ch.sw_row_swept      = s.row_swept;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		expected_results.push_back(advance_sequencer(s));
		ticks_sent++;
	endtask

	// stop offering items and wait for every outstanding result
	task automatic settle_pipeline();
		int n;
		@(negedge clk);
		tick_ch.valid = 1'b0;
		n = 0;
		while (expected_results.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
			mismatches += expected_results.size();
			expected_results.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ignore_ticks(logic [bhs_pkg::CNT_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.unload_ignore_ticks = v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		seq_ignore = v;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_idling(bit tx, bit rx);
		@(negedge clk);
		tick_ch.valid = 1'b0;
		tx_idle_on = tx;
		rx_idle_on = rx;
	endtask

	// from load: push out, push in with bed full
	task automatic enter_unload();
		send_tick(switch_levels(0, 0, 0, 0, 0, 1, 0, 1), 0);
		send_tick(switch_levels(0, 1, 0, 0, 0, 0, 0, 0), 0);
		send_tick(switch_levels(1, 0, 0, 0, 0, 0, 1, 0), 0);
	endtask

	task automatic hold_unload_window(int n);
		bhs_pkg::sw_t s;
		for (int i = 0; i < n; i++) begin
			s = bhs_pkg::sw_t'(8'($urandom_range(0, 255)));
			s.unload_home = 1'b1;
			send_tick(s, 1'b1);
		end
	endtask

	task automatic test_home_and_cycles();
		send_tick(switch_levels(0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_tick(switch_levels(1, 0, 0, 0, 0, 0, 0, 0), 0);
		send_tick(switch_levels(1, 0, 1, 0, 0, 0, 0, 0), 0);
		// push arm away again: later relays keep their level
		send_tick(switch_levels(0, 1, 1, 1, 0, 1, 1, 1), 0);
		send_tick(switch_levels(1, 1, 1, 1, 1, 1, 1, 1), 0);
		send_tick(switch_levels(1, 1, 1, 1, 1, 0, 1, 1), 0);
		send_tick(switch_levels(0, 0, 0, 0, 0, 1, 0, 0), 0);
		send_tick(switch_levels(1, 1, 1, 0, 1, 1, 1, 1), 0);
		send_tick(switch_levels(0, 0, 0, 1, 0, 0, 0, 0), 0);
		send_tick(switch_levels(1, 1, 0, 1, 1, 1, 1, 1), 0);
		send_tick(switch_levels(0, 0, 1, 0, 0, 0, 0, 0), 0);
		send_tick(switch_levels(0, 0, 0, 0, 0, 1, 0, 1), 0);
		send_tick(switch_levels(1, 0, 1, 1, 1, 1, 0, 1), 0);
		send_tick(switch_levels(0, 0, 0, 0, 0, 0, 1, 0), 0);
		send_tick(switch_levels(0, 1, 1, 1, 1, 1, 1, 1), 0);
		send_tick(switch_levels(1, 0, 0, 0, 0, 0, 0, 0), 0);
		enter_unload();
		// default window stays open, then is cut short
		set_idling(0, 0);
		hold_unload_window(100);
		set_idling(1, 1);
		settle_pipeline();
		write_ignore_ticks(bhs_pkg::CNT_W'(100));
		send_tick(switch_levels(1, 1, 1, 1, 0, 1, 1, 1), 0);
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		settle_pipeline();
	endtask

	task automatic test_window_extremes();
		write_ignore_ticks('0);
		enter_unload();
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		settle_pipeline();
		write_ignore_ticks(bhs_pkg::CNT_MAX);
		enter_unload();
		set_idling(0, 0);
		hold_unload_window(100);
		set_idling(1, 1);
		settle_pipeline();
		write_ignore_ticks(bhs_pkg::CNT_W'(100));
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		// lowering the register mid-window
		enter_unload();
		hold_unload_window(5);
		settle_pipeline();
		write_ignore_ticks(bhs_pkg::CNT_W'(2));
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		send_tick(switch_levels(1, 1, 1, 1, 0, 1, 1, 1), 0);
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		settle_pipeline();
		write_ignore_ticks(bhs_pkg::CNT_W'(1));
		enter_unload();
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		send_tick(switch_levels(0, 0, 0, 0, 1, 0, 0, 0), 0);
		settle_pipeline();
	endtask

	task automatic test_backpressure();
		hold_len = 300;
		-> hold_go;
		for (int i = 0; i < 40; i++)
			send_tick(steer_switches(), 1'b1);
		settle_pipeline();
	endtask

	task automatic test_random_sequences();
		logic [bhs_pkg::CNT_W-1:0] ignore_set[5];
		ignore_set[0] = '0;
		ignore_set[1] = bhs_pkg::CNT_W'($urandom_range(1, 8));
		ignore_set[2] = bhs_pkg::CNT_W'(1);
		ignore_set[3] = bhs_pkg::CNT_W'($urandom_range(0, 20));
		ignore_set[4] = bhs_pkg::CNT_W'($urandom_range(2, 6));
		for (int r = 0; r < 5; r++) begin
			write_ignore_ticks(ignore_set[r]);
			case (r)
				1: set_idling(1, 0);
				2: set_idling(0, 1);
				4: set_idling(0, 0);
				default: set_idling(1, 1);
			endcase
			for (int i = 0; i < 170; i++) begin
				if ($urandom_range(0, 99) < 85)
					send_tick(steer_switches(), 1'b0);
				else
					send_tick(bhs_pkg::sw_t'(8'($urandom_range(0, 255))), 1'b0);
			end
			settle_pipeline();
		end
		set_idling(1, 1);
	endtask

	// result checker
	always @(posedge clk) begin
		bhs_pkg::result_t due;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual phase %0d wait %0d",
					$time, res_ch.phase_code, res_ch.wait_code);
				mismatches++;
			end else begin
				due = expected_results.pop_front();
				check_field("phase_code", due.phase_code, res_ch.phase_code);
				check_field("relay_push_out", 3'(due.relay[bhs_pkg::RB_PUSH_OUT]),
					3'(res_ch.relay_push_out));
				check_field("relay_push_in", 3'(due.relay[bhs_pkg::RB_PUSH_IN]),
					3'(res_ch.relay_push_in));
				check_field("relay_sweep_out", 3'(due.relay[bhs_pkg::RB_SWEEP_OUT]),
					3'(res_ch.relay_sweep_out));
				check_field("relay_sweep_in", 3'(due.relay[bhs_pkg::RB_SWEEP_IN]),
					3'(res_ch.relay_sweep_in));
				check_field("relay_load_chain", 3'(due.relay[bhs_pkg::RB_LOAD]),
					3'(res_ch.relay_load_chain));
				check_field("relay_unload_chain", 3'(due.relay[bhs_pkg::RB_UNLOAD]),
					3'(res_ch.relay_unload_chain));
				check_field("wait_code", due.wait_code, res_ch.wait_code);
			end
		end
	end

	// long receiver hold-off
	initial begin
		forever begin
			@(hold_go);
			@(posedge clk);
			rx_hold = 1'b1;
			repeat (hold_len) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	// result receiver
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 16) : 0;
			@(negedge clk);
			while (stall > 0 || rx_hold) begin
				res_ch.ready = 1'b0;
				if (stall > 0)
					stall--;
				@(negedge clk);
			end
			res_ch.ready = 1'b1;
			@(posedge clk);
			while (res_ch.valid !== 1'b1) @(posedge clk);
		end
	end

	initial begin
		#80_000_000;
		$display("%0t: run timed out", $time);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		{tick_ch.sw_push_home, tick_ch.sw_push_extended, tick_ch.sw_sweep_home,
			tick_ch.sw_sweep_extended, tick_ch.sw_unload_home, tick_ch.sw_row_ready,
			tick_ch.sw_load_full, tick_ch.sw_row_swept} = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.unload_ignore_ticks = '0;
		seq_phase  = bhs_pkg::PH_HOME;
		seq_relay  = '0;
		seq_done   = 1'b0;
		seq_count  = '0;
		seq_ignore = bhs_pkg::IGNORE_RESET;
		foreach (phase_hits[i])
			phase_hits[i] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_home_and_cycles();
		test_window_extremes();
		test_backpressure();
		test_random_sequences();
		settle_pipeline();

		$display("Summary: %0d switch items, %0d results, %0d unload runs, %0d cfg writes",
			ticks_sent, results_seen, unload_runs, cfg_writes);
		$display("Ticks per phase home..unload: %0d %0d %0d %0d %0d %0d %0d",
			phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4],
			phase_hits[5], phase_hits[6]);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bhs_pkg.sv
rtl/bhs_ifs.sv
rtl/bhs_step.sv
rtl/bale_handler_sequencer_top.sv
tb/tb_top.sv
